// File: rtl/dcm_pkg.sv
package dcm_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS = 16;
   localparam int DT_BITS = 16;
   localparam int COEF_WIDTH = 31;
   localparam int WIDE_WIDTH = 64;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [VALUE_WIDTH:0] operand_type;
   typedef logic signed [WIDE_WIDTH-1:0] wide_type;
   typedef logic [COEF_WIDTH-1:0] coef_type;
   typedef logic [DT_BITS-1:0] dt_type;

   localparam wide_type VALUE_MAX_WIDE = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
   localparam wide_type VALUE_MIN_WIDE = -VALUE_MAX_WIDE - 64'sd1;
   localparam value_type VALUE_MAX = VALUE_MAX_WIDE[VALUE_WIDTH-1:0];
   localparam value_type VALUE_MIN = VALUE_MIN_WIDE[VALUE_WIDTH-1:0];

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TORQUE_LIMIT = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRICTION_BAND = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRICTION_STIFFNESS = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DAMPING = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INVERSE_INERTIA = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POSITION_MIN = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POSITION_MAX = 3'd6;

   localparam int STIFFNESS_DEFAULT = 1000;
   localparam coef_type TORQUE_LIMIT_RESET = coef_type'(1) << FRAC_BITS;
   localparam coef_type FRICTION_BAND_RESET = '0;
   localparam coef_type FRICTION_STIFFNESS_RESET =
      coef_type'(STIFFNESS_DEFAULT) << FRAC_BITS;
   localparam coef_type DAMPING_RESET = '0;
   localparam coef_type INVERSE_INERTIA_RESET = coef_type'(1) << FRAC_BITS;

   typedef struct packed {
      coef_type  torque_limit;
      coef_type  friction_band;
      coef_type  friction_stiffness;
      coef_type  damping;
      coef_type  inverse_inertia;
      value_type position_min;
      value_type position_max;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAP,
      ST_MUL_FRIC,
      ST_MUL_DAMP,
      ST_SUM,
      ST_MUL_ACC,
      ST_MUL_DV,
      ST_VEL,
      ST_MUL_DP,
      ST_POS
   } state_type;

   typedef enum logic [2:0] {
      MUL_SEL_FRIC,
      MUL_SEL_DAMP,
      MUL_SEL_ACC,
      MUL_SEL_DV,
      MUL_SEL_DP
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        gap_en;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        fric_en;
      logic        sum_en;
      logic        vel_en;
      logic        pos_en;
   } cmd_type;

   function automatic value_type sat_value(input wide_type v);
      value_type r;
      if (v > VALUE_MAX_WIDE) begin
         r = VALUE_MAX;
      end else if (v < VALUE_MIN_WIDE) begin
         r = VALUE_MIN;
      end else begin
         r = v[VALUE_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/dcm_csr.sv
module dcm_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [dcm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [dcm_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   output dcm_pkg::cfg_type                      cfg
);

   dcm_pkg::cfg_type cfg_ff;
   dcm_pkg::cfg_type cfg_in;
   dcm_pkg::coef_type coef_data;

   assign coef_data = csr_write_data[dcm_pkg::COEF_WIDTH-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            dcm_pkg::CSR_TORQUE_LIMIT:       cfg_in.torque_limit = coef_data;
            dcm_pkg::CSR_FRICTION_BAND:      cfg_in.friction_band = coef_data;
            dcm_pkg::CSR_FRICTION_STIFFNESS: cfg_in.friction_stiffness = coef_data;
            dcm_pkg::CSR_DAMPING:            cfg_in.damping = coef_data;
            dcm_pkg::CSR_INVERSE_INERTIA:    cfg_in.inverse_inertia = coef_data;
            dcm_pkg::CSR_POSITION_MIN: begin
               cfg_in.position_min = csr_write_data[dcm_pkg::VALUE_WIDTH-1:0];
            end
            dcm_pkg::CSR_POSITION_MAX: begin
               cfg_in.position_max = csr_write_data[dcm_pkg::VALUE_WIDTH-1:0];
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.torque_limit       <= dcm_pkg::TORQUE_LIMIT_RESET;
         cfg_ff.friction_band      <= dcm_pkg::FRICTION_BAND_RESET;
         cfg_ff.friction_stiffness <= dcm_pkg::FRICTION_STIFFNESS_RESET;
         cfg_ff.damping            <= dcm_pkg::DAMPING_RESET;
         cfg_ff.inverse_inertia    <= dcm_pkg::INVERSE_INERTIA_RESET;
         cfg_ff.position_min       <= dcm_pkg::VALUE_MIN;
         cfg_ff.position_max       <= dcm_pkg::VALUE_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/dcm_ctrl.sv
module dcm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dcm_pkg::cmd_type cmd
);

   dcm_pkg::state_type state_ff;
   dcm_pkg::state_type state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic slot_free;

   // The result register may be refilled in the same cycle its transfer completes.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dcm_pkg::ST_IDLE:     if (req_valid) state_in = dcm_pkg::ST_GAP;
         dcm_pkg::ST_GAP:      state_in = dcm_pkg::ST_MUL_FRIC;
         dcm_pkg::ST_MUL_FRIC: state_in = dcm_pkg::ST_MUL_DAMP;
         dcm_pkg::ST_MUL_DAMP: state_in = dcm_pkg::ST_SUM;
         dcm_pkg::ST_SUM:      state_in = dcm_pkg::ST_MUL_ACC;
         dcm_pkg::ST_MUL_ACC:  state_in = dcm_pkg::ST_MUL_DV;
         dcm_pkg::ST_MUL_DV:   state_in = dcm_pkg::ST_VEL;
         dcm_pkg::ST_VEL:      state_in = dcm_pkg::ST_MUL_DP;
         dcm_pkg::ST_MUL_DP:   state_in = dcm_pkg::ST_POS;
         dcm_pkg::ST_POS:      if (slot_free) state_in = dcm_pkg::ST_IDLE;
         default:              state_in = dcm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.mul_sel = dcm_pkg::MUL_SEL_FRIC;
      case (state_ff)
         dcm_pkg::ST_IDLE: cmd.load = req_valid;
         dcm_pkg::ST_GAP:  cmd.gap_en = 1'b1;
         dcm_pkg::ST_MUL_FRIC: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = dcm_pkg::MUL_SEL_FRIC;
         end
         dcm_pkg::ST_MUL_DAMP: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = dcm_pkg::MUL_SEL_DAMP;
            cmd.fric_en = 1'b1;
         end
         dcm_pkg::ST_SUM: cmd.sum_en = 1'b1;
         dcm_pkg::ST_MUL_ACC: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = dcm_pkg::MUL_SEL_ACC;
         end
         dcm_pkg::ST_MUL_DV: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = dcm_pkg::MUL_SEL_DV;
         end
         dcm_pkg::ST_VEL: cmd.vel_en = 1'b1;
         dcm_pkg::ST_MUL_DP: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = dcm_pkg::MUL_SEL_DP;
         end
         dcm_pkg::ST_POS: cmd.pos_en = slot_free;
         default: cmd = '0;
      endcase
   end

   assign rsp_valid_in = cmd.pos_en || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dcm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == dcm_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == dcm_pkg::ST_GAP))
      else $error("accepted item did not start the gap step");

   a_single_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.gap_en, cmd.sum_en, cmd.vel_en, cmd.pos_en}))
      else $error("more than one datapath step enabled");

   a_result_posted: assert property (@(posedge clock) disable iff (reset)
      cmd.pos_en |=> (rsp_valid_ff && state_ff == dcm_pkg::ST_IDLE))
      else $error("finished item did not reach the result register");

   a_hold_on_full_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dcm_pkg::ST_POS && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == dcm_pkg::ST_POS))
      else $error("result overwritten while the previous one was pending");
`endif

endmodule

// File: rtl/dcm_dp.sv
module dcm_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  dcm_pkg::cfg_type          cfg,
   input  dcm_pkg::cmd_type          cmd,
   input  dcm_pkg::value_type        req_motor_torque_cmd,
   input  dcm_pkg::value_type        req_load_torque,
   input  dcm_pkg::dt_type           req_time_step,
   output dcm_pkg::value_type        rsp_motor_position,
   output dcm_pkg::value_type        rsp_motor_velocity,
   output dcm_pkg::value_type        rsp_net_effort,
   output logic                      rsp_at_limit,
   output logic                      rsp_torque_clamped
);

   // Model state.
   dcm_pkg::value_type position_ff;
   dcm_pkg::value_type velocity_ff;
   dcm_pkg::value_type anchor_ff;
   dcm_pkg::value_type anchor_in;

   // Per-item working registers.
   dcm_pkg::value_type cmd_ff;
   dcm_pkg::value_type cmd_in;
   logic               clamped_ff;
   logic               clamped_in;
   dcm_pkg::value_type load_ff;
   dcm_pkg::dt_type    dt_ff;
   dcm_pkg::value_type gap_ff;
   dcm_pkg::value_type fric_ff;
   dcm_pkg::value_type effort_ff;
   dcm_pkg::wide_type  prod_ff;

   dcm_pkg::wide_type    prod_frac;
   dcm_pkg::wide_type    prod_dt;
   dcm_pkg::operand_type mul_a;
   dcm_pkg::value_type   mul_b;
   dcm_pkg::wide_type    product;

   dcm_pkg::wide_type cmd_wide;
   dcm_pkg::wide_type limit_wide;
   dcm_pkg::wide_type band_wide;
   dcm_pkg::wide_type pos_wide;
   dcm_pkg::wide_type gap_raw;
   dcm_pkg::wide_type newpos;
   dcm_pkg::value_type pos_final;
   logic at_min;
   logic at_max;

   assign prod_frac = prod_ff >>> dcm_pkg::FRAC_BITS;
   assign prod_dt = prod_ff >>> dcm_pkg::DT_BITS;

   // Torque clamp and anchor update for a newly accepted item.
   always_comb begin
      cmd_wide = dcm_pkg::wide_type'(req_motor_torque_cmd);
      limit_wide = dcm_pkg::wide_type'(cfg.torque_limit);
      cmd_in = req_motor_torque_cmd;
      clamped_in = 1'b0;
      if (cmd_wide > limit_wide) begin
         cmd_in = limit_wide[dcm_pkg::VALUE_WIDTH-1:0];
         clamped_in = 1'b1;
      end else if (cmd_wide < -limit_wide) begin
         cmd_in = dcm_pkg::sat_value(-limit_wide);
         clamped_in = 1'b1;
      end

      band_wide = dcm_pkg::wide_type'(cfg.friction_band);
      pos_wide = dcm_pkg::wide_type'(position_ff);
      gap_raw = pos_wide - dcm_pkg::wide_type'(anchor_ff);
      anchor_in = anchor_ff;
      if (gap_raw < -band_wide) begin
         anchor_in = dcm_pkg::sat_value(pos_wide + band_wide);
      end else if (gap_raw > band_wide) begin
         anchor_in = dcm_pkg::sat_value(pos_wide - band_wide);
      end
   end

   // Shared multiplier: one unsigned coefficient or time step times one signed value.
   always_comb begin
      case (cmd.mul_sel)
         dcm_pkg::MUL_SEL_FRIC: begin
            mul_a = dcm_pkg::operand_type'(cfg.friction_stiffness);
            mul_b = gap_ff;
         end
         dcm_pkg::MUL_SEL_DAMP: begin
            mul_a = dcm_pkg::operand_type'(cfg.damping);
            mul_b = velocity_ff;
         end
         dcm_pkg::MUL_SEL_ACC: begin
            mul_a = dcm_pkg::operand_type'(cfg.inverse_inertia);
            mul_b = effort_ff;
         end
         dcm_pkg::MUL_SEL_DV: begin
            // The acceleration is saturated straight out of the product register.
            mul_a = dcm_pkg::operand_type'(dt_ff);
            mul_b = dcm_pkg::sat_value(prod_frac);
         end
         dcm_pkg::MUL_SEL_DP: begin
            mul_a = dcm_pkg::operand_type'(dt_ff);
            mul_b = velocity_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      product = dcm_pkg::wide_type'(mul_a) * dcm_pkg::wide_type'(mul_b);
   end

   // Position update with limit check on the unsaturated sum; the lower limit wins.
   always_comb begin
      newpos = dcm_pkg::wide_type'(position_ff) + prod_dt;
      at_min = newpos < dcm_pkg::wide_type'(cfg.position_min);
      at_max = newpos > dcm_pkg::wide_type'(cfg.position_max);
      if (at_min) begin
         pos_final = cfg.position_min;
      end else if (at_max) begin
         pos_final = cfg.position_max;
      end else begin
         pos_final = dcm_pkg::sat_value(newpos);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         velocity_ff <= '0;
         anchor_ff <= '0;
      end else begin
         if (cmd.load) begin
            anchor_ff <= anchor_in;
         end
         if (cmd.vel_en) begin
            velocity_ff <= dcm_pkg::sat_value(dcm_pkg::wide_type'(velocity_ff) + prod_dt);
         end else if (cmd.pos_en && (at_min || at_max)) begin
            velocity_ff <= '0;
         end
         if (cmd.pos_en) begin
            position_ff <= pos_final;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= cmd_in;
         clamped_ff <= clamped_in;
         load_ff <= req_load_torque;
         dt_ff <= req_time_step;
      end
      if (cmd.gap_en) begin
         gap_ff <= dcm_pkg::sat_value(dcm_pkg::wide_type'(position_ff)
                                      - dcm_pkg::wide_type'(anchor_ff));
      end
      if (cmd.mul_en) begin
         prod_ff <= product;
      end
      if (cmd.fric_en) begin
         fric_ff <= dcm_pkg::sat_value(prod_frac);
      end
      if (cmd.sum_en) begin
         effort_ff <= dcm_pkg::sat_value(dcm_pkg::wide_type'(cmd_ff)
                                         + dcm_pkg::wide_type'(load_ff)
                                         + dcm_pkg::wide_type'(fric_ff)
                                         - prod_frac);
      end
      if (cmd.pos_en) begin
         rsp_motor_position <= pos_final;
         rsp_motor_velocity <= (at_min || at_max) ? '0 : velocity_ff;
         rsp_net_effort <= (at_min || at_max) ? '0 : effort_ff;
         rsp_at_limit <= at_min || at_max;
         rsp_torque_clamped <= clamped_ff;
      end
   end

endmodule

// File: rtl/dc_motor_friction_model_step_top.sv
// DC motor tick model: every accepted request advances a rotor with inertia, viscous
// damping and anchor friction by one forward-Euler step of length req_time_step (Q0.16
// seconds) and returns one response with the new position and velocity, the net torque
// and two flags. Torques, positions and velocities are signed Q16.16 and saturate;
// coefficients are unsigned Q15.16. Each request passes the anchor and gap steps, the
// five products formed one per cycle on one shared 33x32-bit multiplier, and the sum,
// velocity and position steps that take their scaled results. A new request is taken
// in the cycle after the previous response is loaded, while that response may still
// wait in the output register. Coefficients and limits are written through the csr_
// port; the user must write them only while no request is in flight, which the block
// itself does not enforce. They are cleared to their defaults by reset, as are
// position, velocity and the friction anchor.
module dc_motor_friction_model_step_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [dcm_pkg::VALUE_WIDTH-1:0] req_motor_torque_cmd,
   input  logic signed [dcm_pkg::VALUE_WIDTH-1:0] req_load_torque,
   input  logic [dcm_pkg::DT_BITS-1:0]            req_time_step,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [dcm_pkg::VALUE_WIDTH-1:0] rsp_motor_position,
   output logic signed [dcm_pkg::VALUE_WIDTH-1:0] rsp_motor_velocity,
   output logic signed [dcm_pkg::VALUE_WIDTH-1:0] rsp_net_effort,
   output logic                                  rsp_at_limit,
   output logic                                  rsp_torque_clamped,
   input  logic                                  csr_write_en,
   input  logic [dcm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [dcm_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   dcm_pkg::cfg_type cfg;
   dcm_pkg::cmd_type cmd;

   dcm_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   dcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   dcm_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .cmd                  (cmd),
      .req_motor_torque_cmd (req_motor_torque_cmd),
      .req_load_torque      (req_load_torque),
      .req_time_step        (req_time_step),
      .rsp_motor_position   (rsp_motor_position),
      .rsp_motor_velocity   (rsp_motor_velocity),
      .rsp_net_effort       (rsp_net_effort),
      .rsp_at_limit         (rsp_at_limit),
      .rsp_torque_clamped   (rsp_torque_clamped)
   );

endmodule

// File: sim/dc_motor_friction_model_step_top_tb.sv
module dc_motor_friction_model_step_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Q_ONE = 1 << dcm_pkg::FRAC_BITS;
   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_PHASES = 10;
   localparam int TICKS_PER_PHASE = 123;
   localparam logic [dcm_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE = 3'd7;

   typedef struct packed {
      dcm_pkg::value_type torque_cmd;
      dcm_pkg::value_type load;
      dcm_pkg::dt_type    step;
   } tick_req_type;

   typedef struct packed {
      dcm_pkg::value_type position;
      dcm_pkg::value_type velocity;
      dcm_pkg::value_type effort;
      logic               at_limit;
      logic               clamped;
   } tick_rsp_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic signed [dcm_pkg::VALUE_WIDTH-1:0] req_motor_torque_cmd = '0;
   logic signed [dcm_pkg::VALUE_WIDTH-1:0] req_load_torque = '0;
   logic [dcm_pkg::DT_BITS-1:0]            req_time_step = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic signed [dcm_pkg::VALUE_WIDTH-1:0] rsp_motor_position;
   logic signed [dcm_pkg::VALUE_WIDTH-1:0] rsp_motor_velocity;
   logic signed [dcm_pkg::VALUE_WIDTH-1:0] rsp_net_effort;
   logic                                  rsp_at_limit;
   logic                                  rsp_torque_clamped;
   logic                                  csr_write_en = 1'b0;
   logic [dcm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index = '0;
   logic [dcm_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data = '0;

   // Shadow of the plant: its registers and its mechanical state.
   dcm_pkg::cfg_type plant_cfg;
   longint  shaft_pos;
   longint  shaft_vel;
   longint  stick_anchor;

   tick_req_type ticks_pending[$];
   tick_rsp_type ticks_expected[$];

   bit back_to_back = 1'b0;
   bit req_sent = 1'b0;
   bit rsp_taken = 1'b0;
   int req_gap = 0;
   int rsp_wait = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int ticks_checked = 0;
   int limit_hits = 0;
   int clamp_hits = 0;
   int settings_count = 0;

   dc_motor_friction_model_step_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_motor_torque_cmd (req_motor_torque_cmd),
      .req_load_torque      (req_load_torque),
      .req_time_step        (req_time_step),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_motor_position   (rsp_motor_position),
      .rsp_motor_velocity   (rsp_motor_velocity),
      .rsp_net_effort       (rsp_net_effort),
      .rsp_at_limit         (rsp_at_limit),
      .rsp_torque_clamped   (rsp_torque_clamped),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint clip_q(input longint v);
      if (v > dcm_pkg::VALUE_MAX_WIDE) begin
         return dcm_pkg::VALUE_MAX_WIDE;
      end else if (v < dcm_pkg::VALUE_MIN_WIDE) begin
         return dcm_pkg::VALUE_MIN_WIDE;
      end
      return v;
   endfunction

   // Exact product scaled down, rounding toward minus infinity.
   function automatic longint scaled_mul(input longint a, input longint b, input int sh);
      return (a * b) >>> sh;
   endfunction

   function automatic void plant_reset();
      plant_cfg.torque_limit = dcm_pkg::TORQUE_LIMIT_RESET;
      plant_cfg.friction_band = dcm_pkg::FRICTION_BAND_RESET;
      plant_cfg.friction_stiffness = dcm_pkg::FRICTION_STIFFNESS_RESET;
      plant_cfg.damping = dcm_pkg::DAMPING_RESET;
      plant_cfg.inverse_inertia = dcm_pkg::INVERSE_INERTIA_RESET;
      plant_cfg.position_min = dcm_pkg::VALUE_MIN;
      plant_cfg.position_max = dcm_pkg::VALUE_MAX;
      shaft_pos = 0;
      shaft_vel = 0;
      stick_anchor = 0;
   endfunction

   // One forward-Euler tick of the motor.
   function automatic tick_rsp_type motor_tick(input tick_req_type t);
      tick_rsp_type r;
      longint cmd, lim, band, gap, fric, eff, acc, npos, dt;
      cmd = longint'(t.torque_cmd);
      dt = longint'(t.step);
      lim = longint'(plant_cfg.torque_limit);
      band = longint'(plant_cfg.friction_band);
      r.clamped = 1'b0;
      r.at_limit = 1'b0;
      if (cmd > lim) begin
         cmd = lim;
         r.clamped = 1'b1;
      end
      if (cmd < -lim) begin
         cmd = -lim;
         r.clamped = 1'b1;
      end
      gap = shaft_pos - stick_anchor;
      if (gap < -band) begin
         stick_anchor = clip_q(shaft_pos + band);
      end else if (gap > band) begin
         stick_anchor = clip_q(shaft_pos - band);
      end
      gap = clip_q(shaft_pos - stick_anchor);
      fric = clip_q(scaled_mul(longint'(plant_cfg.friction_stiffness), gap,
                               dcm_pkg::FRAC_BITS));
      eff = clip_q(cmd + longint'(t.load) + fric
                   - scaled_mul(longint'(plant_cfg.damping), shaft_vel, dcm_pkg::FRAC_BITS));
      acc = clip_q(scaled_mul(eff, longint'(plant_cfg.inverse_inertia), dcm_pkg::FRAC_BITS));
      shaft_vel = clip_q(shaft_vel + scaled_mul(acc, dt, dcm_pkg::DT_BITS));
      npos = shaft_pos + scaled_mul(shaft_vel, dt, dcm_pkg::DT_BITS);
      // The lower limit is tested first, so it wins when the limits are inverted.
      if (npos < longint'(plant_cfg.position_min)) begin
         npos = longint'(plant_cfg.position_min);
         r.at_limit = 1'b1;
      end else if (npos > longint'(plant_cfg.position_max)) begin
         npos = longint'(plant_cfg.position_max);
         r.at_limit = 1'b1;
      end
      shaft_pos = clip_q(npos);
      if (r.at_limit) begin
         shaft_vel = 0;
         eff = 0;
      end
      r.position = dcm_pkg::value_type'(shaft_pos);
      r.velocity = dcm_pkg::value_type'(shaft_vel);
      r.effort = dcm_pkg::value_type'(eff);
      return r;
   endfunction

   task automatic check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic csr_write(input logic [dcm_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [dcm_pkg::CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         dcm_pkg::CSR_TORQUE_LIMIT: begin
            plant_cfg.torque_limit = data[dcm_pkg::COEF_WIDTH-1:0];
         end
         dcm_pkg::CSR_FRICTION_BAND: begin
            plant_cfg.friction_band = data[dcm_pkg::COEF_WIDTH-1:0];
         end
         dcm_pkg::CSR_FRICTION_STIFFNESS: begin
            plant_cfg.friction_stiffness = data[dcm_pkg::COEF_WIDTH-1:0];
         end
         dcm_pkg::CSR_DAMPING: begin
            plant_cfg.damping = data[dcm_pkg::COEF_WIDTH-1:0];
         end
         dcm_pkg::CSR_INVERSE_INERTIA: begin
            plant_cfg.inverse_inertia = data[dcm_pkg::COEF_WIDTH-1:0];
         end
         dcm_pkg::CSR_POSITION_MIN: begin
            plant_cfg.position_min = data;
         end
         dcm_pkg::CSR_POSITION_MAX: begin
            plant_cfg.position_max = data;
         end
         default: begin
         end
      endcase
   endtask

   // The top bit of a coefficient write is don't-care, so it is randomized.
   task automatic program_plant(input dcm_pkg::coef_type tl, input dcm_pkg::coef_type band,
                                input dcm_pkg::coef_type stiff,
                                input dcm_pkg::coef_type damp,
                                input dcm_pkg::coef_type inv,
                                input dcm_pkg::value_type pmin,
                                input dcm_pkg::value_type pmax);
      csr_write(dcm_pkg::CSR_TORQUE_LIMIT, {1'($urandom_range(0, 1)), tl});
      csr_write(dcm_pkg::CSR_FRICTION_BAND, {1'($urandom_range(0, 1)), band});
      csr_write(dcm_pkg::CSR_FRICTION_STIFFNESS, {1'($urandom_range(0, 1)), stiff});
      csr_write(dcm_pkg::CSR_DAMPING, {1'($urandom_range(0, 1)), damp});
      csr_write(dcm_pkg::CSR_INVERSE_INERTIA, {1'($urandom_range(0, 1)), inv});
      csr_write(dcm_pkg::CSR_POSITION_MIN, pmin);
      csr_write(dcm_pkg::CSR_POSITION_MAX, pmax);
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      settings_count++;
   endtask

   task automatic queue_tick(input int cmd, input int load, input int dt);
      tick_req_type t;
      t.torque_cmd = cmd;
      t.load = load;
      t.step = dcm_pkg::dt_type'(dt);
      ticks_pending.push_back(t);
   endtask

   // Mostly plausible torques and short ticks; now and then anything at all.
   function automatic tick_req_type random_tick();
      tick_req_type t;
      if ($urandom_range(0, 9) < 2) begin
         t.torque_cmd = $urandom();
         t.load = $urandom();
         t.step = dcm_pkg::dt_type'($urandom_range(0, 65535));
      end else begin
         t.torque_cmd = $urandom_range(0, 8 * Q_ONE) - 4 * Q_ONE;
         t.load = $urandom_range(0, 4 * Q_ONE) - 2 * Q_ONE;
         t.step = ($urandom_range(0, 15) == 0) ? '0 :
                  dcm_pkg::dt_type'($urandom_range(1, 1500));
      end
      return t;
   endfunction

   task automatic wait_drained();
      do begin
         @(posedge clock);
      end while (ticks_pending.size() != 0 || req_valid || ticks_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin : req_driver
      tick_req_type nxt;
      if (!reset && (!req_valid || req_sent)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (ticks_pending.size() != 0) begin
            nxt = ticks_pending.pop_front();
            req_motor_torque_cmd <= nxt.torque_cmd;
            req_load_torque <= nxt.load;
            req_time_step <= nxt.step;
            req_valid <= 1'b1;
            req_gap = back_to_back ? 0 : $urandom_range(0, 4);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : rsp_receiver
      if (!reset) begin
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (rsp_taken) begin
            rsp_wait = back_to_back ? 0 : $urandom_range(0, 4);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : monitor
      tick_rsp_type want;
      tick_req_type got_req;
      req_sent = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end else begin
            if (rsp_valid && rsp_ready) begin
               rsp_taken = 1'b1;
               if (ticks_expected.size() == 0) begin
                  $error("response transfer with no tick outstanding");
                  mismatch_count++;
               end else begin
                  want = ticks_expected.pop_front();
                  check_field("motor_position", want.position, rsp_motor_position);
                  check_field("motor_velocity", want.velocity, rsp_motor_velocity);
                  check_field("net_effort", want.effort, rsp_net_effort);
                  check_field("at_limit", want.at_limit, rsp_at_limit);
                  check_field("torque_clamped", want.clamped, rsp_torque_clamped);
                  ticks_checked++;
                  limit_hits += want.at_limit;
                  clamp_hits += want.clamped;
               end
            end
            if (req_valid && req_ready) begin
               req_sent = 1'b1;
               got_req.torque_cmd = req_motor_torque_cmd;
               got_req.load = req_load_torque;
               got_req.step = req_time_step;
               ticks_expected.push_back(motor_tick(got_req));
            end
         end
      end
   end

   initial begin : stimulus
      int span;
      dcm_pkg::value_type pmin, pmax;
      dcm_pkg::coef_type tl, band, stiff, damp, inv;
      plant_reset();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: limits at the ends of the range and no friction band.
      queue_tick(0, 0, 0);
      queue_tick(dcm_pkg::VALUE_MAX, 0, 0);
      queue_tick(dcm_pkg::VALUE_MIN, 0, 0);
      queue_tick(Q_ONE, 0, 100);
      queue_tick(-Q_ONE - 1, 0, 100);
      // Full load with the longest tick drives the position out of range.
      queue_tick(0, dcm_pkg::VALUE_MAX, 65535);
      queue_tick(dcm_pkg::VALUE_MAX, dcm_pkg::VALUE_MAX, 65535);
      queue_tick(0, dcm_pkg::VALUE_MIN, 65535);
      queue_tick(0, dcm_pkg::VALUE_MIN, 65535);
      queue_tick(dcm_pkg::VALUE_MIN, dcm_pkg::VALUE_MIN, 65535);
      wait_drained();

      // Narrow limits and a friction band: anchor drag and both limit hits.
      program_plant(dcm_pkg::coef_type'(2 * Q_ONE), dcm_pkg::coef_type'(Q_ONE / 4),
                    dcm_pkg::coef_type'(100 * Q_ONE), dcm_pkg::coef_type'(Q_ONE / 2),
                    dcm_pkg::coef_type'(2 * Q_ONE), -Q_ONE, Q_ONE);
      queue_tick(0, 0, 6554);
      queue_tick(2 * Q_ONE, 0, 6554);
      queue_tick(2 * Q_ONE, 0, 6554);
      queue_tick(Q_ONE / 3, Q_ONE, 0);
      queue_tick(-2 * Q_ONE, 0, 6554);
      queue_tick(-2 * Q_ONE, -Q_ONE, 30000);
      queue_tick(3 * Q_ONE, Q_ONE, 30000);
      queue_tick(0, 0, 3000);
      wait_drained();

      // Inverted limits: the lower one must win.
      program_plant(dcm_pkg::coef_type'(2 * Q_ONE), dcm_pkg::coef_type'(Q_ONE / 4),
                    dcm_pkg::coef_type'(100 * Q_ONE), dcm_pkg::coef_type'(Q_ONE / 2),
                    dcm_pkg::coef_type'(2 * Q_ONE), Q_ONE / 2, -Q_ONE / 2);
      queue_tick(0, 0, 0);
      queue_tick(Q_ONE, 0, 1000);
      queue_tick(-Q_ONE, 0, 1000);
      queue_tick(0, 0, 65535);
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         back_to_back = (ph % 3 == 2);
         if (ph == 0) begin
            csr_write(CSR_SPARE, $urandom());
         end
         tl = (ph == 0) ? '0 : (ph == 1) ? '1 :
              dcm_pkg::coef_type'($urandom_range(0, 8 * Q_ONE));
         band = (ph == 2) ? '1 : (ph == 3) ? '0 :
                dcm_pkg::coef_type'($urandom_range(0, Q_ONE / 2));
         stiff = (ph == 4) ? '0 : (ph == 5) ? '1 :
                 dcm_pkg::coef_type'($urandom_range(0, 1000 * Q_ONE));
         damp = (ph == 6) ? '1 : (ph == 0) ? '0 :
                dcm_pkg::coef_type'($urandom_range(0, 10 * Q_ONE));
         inv = (ph == 7) ? '0 : (ph == 8) ? '1 :
               dcm_pkg::coef_type'($urandom_range(Q_ONE / 2, 4 * Q_ONE));
         if (ph == 1) begin
            pmin = dcm_pkg::VALUE_MIN;
            pmax = dcm_pkg::VALUE_MAX;
         end else if (ph == 9) begin
            pmin = Q_ONE;
            pmax = -Q_ONE;
         end else begin
            span = $urandom_range(Q_ONE / 2, 20 * Q_ONE);
            pmin = -span;
            pmax = $urandom_range(Q_ONE / 2, 20 * Q_ONE);
         end
         program_plant(tl, band, stiff, damp, inv, pmin, pmax);
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            ticks_pending.push_back(random_tick());
         end
         // A long receiver stall while the sender keeps offering ticks.
         if (ph == 3) begin
            hold_requests++;
         end
         wait_drained();
      end

      $display("Ran %0d motor ticks under %0d register settings after reset.",
               ticks_checked, settings_count);
      $display("%0d ticks ended at a position limit, %0d had the command clamped.",
               limit_hits, clamp_hits);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
